// ===== hdl/sobel_edge_magnitude_rgb_unit_assert.svh =====
// Assertion macros for the Sobel edge unit
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH
// implication check under reset
`define SEM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sem: check failed");
// next-cycle implication check under reset
`define SEM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sem: check failed");
`endif

// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and the square-root step used by the filter.
// ----------------------------------------------------------------------------
package sem_pkg;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [12:0] RST_HEIGHT = 13'd480;
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;
	// byte addresses on the APB port
	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	// control for one pixel going into the filter stage
	typedef struct packed {
		logic valid;
		logic up;
		logic down;
		logic left;
		logic right;
		logic last;
	} win_ctl_t;

	// four digits of a restoring square root: takes two bits of the
	// radicand per digit, returns {remainder, partial root}
	function automatic logic [18:0] sqrt_steps(input logic [10:0] rem_in,
		input logic [7:0] root_in, input logic [7:0] pairs);
		logic [10:0] rem;
		logic [7:0]  root;
		logic [10:0] trial;
		begin
			rem = rem_in;
			root = root_in;
			for (int i = 3; i >= 0; i--) begin
				rem = {rem[8:0], pairs[2*i +: 2]};
				trial = {1'b0, root, 2'b01};
				if (rem >= trial) begin
					rem = rem - trial;
					root = {root[6:0], 1'b1};
				end else begin
					root = {root[6:0], 1'b0};
				end
			end
			sqrt_steps = {rem, root};
		end
	endfunction
endpackage

// ===== hdl/sem_line_mem.sv =====
// ----------------------------------------------------------------------------
// sem_line_mem
// Two line stores in one memory: read old (upper, middle), write (middle, new).
// ----------------------------------------------------------------------------
module sem_line_mem import sem_pkg::*; #(
	parameter int MaxWidth = DEF_MAX_WIDTH
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [$clog2(MaxWidth)-1:0] rd_addr,
	output logic [47:0]                 rd_data,
	input  logic                        wr_en,
	input  logic [$clog2(MaxWidth)-1:0] wr_addr,
	input  logic [47:0]                 wr_data
);
	logic [47:0] mem [MaxWidth];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule

// ===== hdl/sem_filter.sv =====
// ----------------------------------------------------------------------------
// sem_filter
// Masked Sobel gradients per channel, squares, then rounded magnitude.
// ----------------------------------------------------------------------------
module sem_filter import sem_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [215:0] win,
	input  win_ctl_t     ctl,
	output logic         out_valid,
	output logic         busy,
	output logic [23:0]  mag,
	output logic         out_last
);
	logic [7:0]  p [3][3][3];
	logic signed [11:0] gx [3];
	logic signed [11:0] gy [3];
	logic [21:0] gx_w [3];
	logic [21:0] gy_w [3];
	logic [21:0] sq [3];
	logic [20:0] sq_s1 [3];
	logic [18:0] hi [3];
	logic [18:0] lo [3];
	logic [8:0]  rnd [3];
	logic [10:0] rem_s2 [3];
	logic [7:0]  root_s2 [3];
	logic [7:0]  low_s2 [3];
	logic        sat_s2 [3];
	logic        v_s1, last_s1;
	logic        v_s2, last_s2;

	assign busy = v_s1 || v_s2;

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					p[k][i][j] = ((i != 0 || ctl.up) && (i != 2 || ctl.down) &&
						(j != 0 || ctl.left) && (j != 2 || ctl.right)) ?
						win[(i*3+j)*24 + (2-k)*8 +: 8] : 8'd0;
		for (int k = 0; k < 3; k++) begin
			gx[k] = 12'(p[k][0][2]) - 12'(p[k][0][0]) + 12'({p[k][1][2], 1'b0})
				- 12'({p[k][1][0], 1'b0}) + 12'(p[k][2][2]) - 12'(p[k][2][0]);
			gy[k] = 12'(p[k][2][0]) - 12'(p[k][0][0]) + 12'({p[k][2][1], 1'b0})
				- 12'({p[k][0][1], 1'b0}) + 12'(p[k][2][2]) - 12'(p[k][0][2]);
			gx_w[k] = {{10{gx[k][11]}}, gx[k]};
			gy_w[k] = {{10{gy[k][11]}}, gy[k]};
			// sum of squares is at most 2*1020^2, under 2^21
			sq[k] = gx_w[k] * gx_w[k] + gy_w[k] * gy_w[k];
			// upper four root digits from bits 15:8, lower four from bits 7:0
			hi[k] = sqrt_steps(11'd0, 8'd0, sq_s1[k][15:8]);
			lo[k] = sqrt_steps(rem_s2[k], root_s2[k], low_s2[k]);
			// round up when s - root^2 > root
			rnd[k] = (lo[k][18:8] > {3'd0, lo[k][7:0]}) ? {1'b0, lo[k][7:0]} + 9'd1 :
				{1'b0, lo[k][7:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid && ctl.valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= ctl.last;
		last_s2 <= last_s1;
		out_last <= last_s2;
		for (int k = 0; k < 3; k++) begin
			sq_s1[k] <= sq[k][20:0];
			rem_s2[k] <= hi[k][18:8];
			root_s2[k] <= hi[k][7:0];
			low_s2[k] <= sq_s1[k][7:0];
			sat_s2[k] <= |sq_s1[k][20:16];
			mag[(2-k)*8 +: 8] <= (sat_s2[k] || rnd[k][8]) ? 8'd255 : rnd[k][7:0];
		end
	end
endmodule

// ===== hdl/sobel_edge_magnitude_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit
// Streaming 3x3 Sobel edge magnitude on RGB pixels, with line-store memory.
// ----------------------------------------------------------------------------
// channel   signals                                         role
// pixel in  valid/ready, pixel_red/green/blue, flush        raster pixels + flush
// edge out  out_valid/out_ready, edge_red/green/blue, last  magnitudes
// config    APB psel/penable/pwrite/paddr/pwdata/prdata     frame_width, height
//
// A pixel transaction goes through accept, line memory read, window shift with
// write-back, then a wait until its result has left the three filter stages and
// the output register is free, so a new pixel is taken only once the last is
// through. A result reaches out_valid via the window register, the three filter
// stages and the output register.
// Reset clears positions, window and control; line memory is left as is.
// The next pixel is held off while a result waits for the output side.
// The result for pixel q comes out with input position q+width+1.
`include "sobel_edge_magnitude_rgb_unit_assert.svh"
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; #(
	parameter int MaxWidth = DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [7:0]  pixel_blue,
	input  logic        flush,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  edge_red,
	output logic [7:0]  edge_green,
	output logic [7:0]  edge_blue,
	output logic        last_pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(MaxWidth);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE, S_WAIT} state_t;
	state_t state_q;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [13:0] w_eff, h_eff;
	logic [12:0] col_q;
	logic [13:0] row_q;
	logic [23:0] px_q;
	logic [215:0] win_q;
	logic [47:0] rd_data;
	win_ctl_t ctl_q;
	logic        fvalid_q;
	logic        f_valid;
	logic        f_busy;
	logic [23:0] f_mag;
	logic        f_last;
	logic        cfg_wr;
	logic        unused_flush;
	logic [12:0] c_use;
	logic [13:0] r_use;
	logic        cvalid;
	logic [13:0] qr, qc;
	logic        clast;

	assign unused_flush = flush; // flush items are treated by position alone
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, height_q} : {21'd0, width_q};

	always_comb begin
		if (width_q == 11'd0) w_eff = 14'd1;
		else if ({3'd0, width_q} > 14'(MaxWidth)) w_eff = 14'(MaxWidth);
		else w_eff = {3'd0, width_q};
		if (height_q == 13'd0) h_eff = 14'd1;
		else if ({1'b0, height_q} > 14'(MAX_HEIGHT)) h_eff = 14'(MAX_HEIGHT);
		else h_eff = {1'b0, height_q};
		c_use = ({1'b0, col_q} >= w_eff) ? 13'd0 : col_q;
		r_use = (row_q > h_eff + 14'd1) ? 14'd0 : row_q;
		if (c_use != 13'd0) begin
			cvalid = r_use >= 14'd1 && r_use <= h_eff;
			qr = r_use - 14'd1;
			qc = {1'b0, c_use} - 14'd1;
		end else begin
			cvalid = r_use >= 14'd2 && r_use <= h_eff + 14'd1;
			qr = r_use - 14'd2;
			qc = w_eff - 14'd1;
		end
		clast = cvalid && qr == h_eff - 14'd1 && qc == w_eff - 14'd1;
	end

	sem_line_mem #(.MaxWidth(MaxWidth)) u_mem (
		.clk    (clk),
		.rd_en  (state_q == S_READ),
		.rd_addr(c_use[AW-1:0]),
		.rd_data(rd_data),
		.wr_en  (state_q == S_WRITE),
		.wr_addr(c_use[AW-1:0]),
		.wr_data({rd_data[23:0], px_q})
	);

	assign ready = state_q == S_IDLE;

	// sequencer: accept, read line memory, shift window and write back, wait for output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
			fvalid_q <= 1'b0;
			ctl_q <= '0;
		end else begin
			fvalid_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == REG_WIDTH) width_q <= pwdata[10:0];
				else height_q <= pwdata[12:0];
				col_q <= '0;
				row_q <= '0;
				win_q <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (valid) state_q <= S_READ;
					end
					S_READ: state_q <= S_WRITE;
					S_WRITE: begin
						for (int k = 0; k < 3; k++) begin
							win_q[(k*3)*24 +: 24] <= win_q[(k*3+1)*24 +: 24];
							win_q[(k*3+1)*24 +: 24] <= win_q[(k*3+2)*24 +: 24];
						end
						win_q[2*24 +: 24] <= rd_data[47:24];
						win_q[5*24 +: 24] <= rd_data[23:0];
						win_q[8*24 +: 24] <= px_q;
						ctl_q.valid <= cvalid;
						ctl_q.up    <= qr >= 14'd1;
						ctl_q.down  <= qr + 14'd1 < h_eff;
						ctl_q.left  <= qc >= 14'd1;
						ctl_q.right <= qc + 14'd1 < w_eff;
						ctl_q.last  <= clast;
						fvalid_q <= 1'b1;
						if (clast) begin
							col_q <= '0;
							row_q <= '0;
						end else if ({1'b0, c_use} + 14'd1 >= w_eff) begin
							col_q <= '0;
							row_q <= r_use + 14'd1;
						end else begin
							col_q <= c_use + 13'd1;
							row_q <= r_use;
						end
						state_q <= S_WAIT;
					end
					S_WAIT: begin
						// filter empty and output register free or draining
						if (!fvalid_q && !f_busy && !f_valid && (!out_valid || out_ready))
							state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && valid)
			px_q <= {pixel_red, pixel_green, pixel_blue};
	end

	sem_filter u_filt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fvalid_q),
		.win      (win_q),
		.ctl      (ctl_q),
		.out_valid(f_valid),
		.busy     (f_busy),
		.mag      (f_mag),
		.out_last (f_last)
	);

	// output register; the WAIT state keeps a new pixel out until it drains
	logic       ov_q;
	logic [24:0] od_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (f_valid) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (f_valid) od_q <= {f_last, f_mag};
	end
	assign out_valid  = ov_q;
	assign edge_red   = od_q[23:16];
	assign edge_green = od_q[15:8];
	assign edge_blue  = od_q[7:0];
	assign last_pixel = od_q[24];

	`SEM_ASSERT_IMP(a_ready_idle, ready, state_q == S_IDLE)
	`SEM_ASSERT_NXT(a_read_follows, state_q == S_READ && !cfg_wr, state_q == S_WRITE)
	`SEM_ASSERT_IMP(a_col_range, state_q == S_WRITE, {1'b0, c_use} < w_eff)
	`SEM_ASSERT_IMP(a_no_overrun, f_valid, !ov_q || out_ready)
endmodule

// ===== tb/sem_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sem_checker
// Watches the pixel, edge and APB ports of the Sobel unit. It keeps its own
// line stores, window and frame position, predicts each edge transaction and
// compares the results in order.
// ----------------------------------------------------------------------------
module sem_checker import sem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [7:0]  pixel_blue,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  edge_red,
	input  logic [7:0]  edge_green,
	input  logic [7:0]  edge_blue,
	input  logic        last_pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          edges_pending
);
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} edge_t;

	edge_t       edge_q[$];
	logic [23:0] upper_mem [DEF_MAX_WIDTH];
	logic [23:0] middle_mem [DEF_MAX_WIDTH];
	logic [23:0] win [3][3];
	int unsigned col_pos, row_pos;
	logic [10:0] width_reg;
	logic [12:0] height_reg;

	assign edges_pending = edge_q.size();

	// rounded square root, saturated
	function automatic logic [7:0] round_root(int unsigned s);
		int unsigned r;
		if (s > 65280) return 8'd255;
		r = 0;
		for (int k = 7; k >= 0; k--)
			if ((r | (1 << k)) * (r | (1 << k)) <= s) r = r | (1 << k);
		if (s > r * r + r) r++;
		return (r > 255) ? 8'd255 : 8'(r);
	endfunction

	function automatic void restart_frame();
		foreach (win[i, j]) win[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
	endfunction

	task automatic predict_pixel(input logic [23:0] px);
		int unsigned w, h, c, r, qr, qc;
		logic [23:0] top, mid;
		logic hit, up, down, left, right, last, ok;
		int p [3][3];
		int gx, gy;
		logic [7:0] mag [3];
		w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		c = col_pos;
		r = row_pos;
		if (c >= w) c = 0;
		if (r > h + 1) r = 0;
		top = upper_mem[c];
		mid = middle_mem[c];
		upper_mem[c] = mid;
		middle_mem[c] = px;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;
		// result lags by one row and one column; column 0 closes the row above
		if (c >= 1) begin
			hit = (r >= 1) && (r <= h);
			qr = r - 1;
			qc = c - 1;
		end else begin
			hit = (r >= 2) && (r <= h + 1);
			qr = r - 2;
			qc = w - 1;
		end
		last = hit && (qr == h - 1) && (qc == w - 1);
		if (hit) begin
			up = qr >= 1;
			down = qr + 1 < h;
			left = qc >= 1;
			right = qc + 1 < w;
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						ok = (i != 0 || up) && (i != 2 || down) &&
							(j != 0 || left) && (j != 2 || right);
						p[i][j] = ok ? int'(win[i][j][16 - 8 * ch +: 8]) : 0;
					end
				gx = -p[0][0] + p[0][2] - 2 * p[1][0] + 2 * p[1][2] - p[2][0] + p[2][2];
				gy = -p[0][0] - 2 * p[0][1] - p[0][2] + p[2][0] + 2 * p[2][1] + p[2][2];
				mag[ch] = round_root(gx * gx + gy * gy);
			end
			edge_q.push_back('{mag[0], mag[1], mag[2], last});
		end
		if (last) begin
			c = 0;
			r = 0;
		end else begin
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_t got, want;
		if (!arst_n) begin
			edge_q.delete();
			foreach (upper_mem[i]) begin
				upper_mem[i] = '0;
				middle_mem[i] = '0;
			end
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			fail_count = 0;
			restart_frame();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_WIDTH) begin
					width_reg = pwdata[10:0];
					restart_frame();
				end else if (paddr == ADDR_HEIGHT) begin
					height_reg = pwdata[12:0];
					restart_frame();
				end
			end
			if (valid && ready)
				predict_pixel({pixel_red, pixel_green, pixel_blue});
			if (out_valid && out_ready) begin
				got = '{edge_red, edge_green, edge_blue, last_pixel};
				if (edge_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected edge transaction %h", got);
				end else begin
					want = edge_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("edge mismatch: exp r%h g%h b%h l%b, got r%h g%h b%h l%b",
								want.red, want.green, want.blue, want.last,
								got.red, got.green, got.blue, got.last);
					end
				end
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frames of RGB pixels plus flush transactions into the Sobel unit,
// reprograms the frame size between frames over APB and leaves the checking
// to sem_checker. Frames are mostly tiny; one is wide and runs without idling.
// ----------------------------------------------------------------------------
module testbench import sem_pkg::*;;
	localparam int HOLD_OFF = 30; // pipeline settle before a register write

	logic        clk, arst_n;
	logic        valid, ready, flush;
	logic [7:0]  pixel_red, pixel_green, pixel_blue;
	logic        out_valid, out_ready, last_pixel;
	logic [7:0]  edge_red, edge_green, edge_blue;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, edges_pending;
	bit          calm;     // no idling on either side while set
	int          rand_sent;
	int unsigned cur_w, cur_h;

	sobel_edge_magnitude_rgb_unit u_top (.*);

	sem_checker u_chk (
		.clk, .arst_n, .valid, .ready, .pixel_red, .pixel_green, .pixel_blue,
		.out_valid, .out_ready, .edge_red, .edge_green, .edge_blue, .last_pixel,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .edges_pending
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// edge side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= calm || ($urandom_range(99) >= 24);
	end

	// one pixel transaction; valid only drops when an idle gap is taken
	task automatic send_pixel(input logic [7:0] r, g, b, input logic f);
		bit took;
		if (!calm && $urandom_range(99) < 24) begin
			valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		valid <= 1'b1;
		pixel_red <= r;
		pixel_green <= g;
		pixel_blue <= b;
		flush <= f;
		forever begin
			@(negedge clk);
			took = ready;
			@(posedge clk);
			if (took) break;
		end
	endtask

	// wait for all edges, let the pipeline empty, then write over APB
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		valid <= 1'b0;
		@(posedge clk);
		while (edges_pending != 0) @(negedge clk);
		repeat (HOLD_OFF) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [7:0] rand_level(input bit extreme);
		if (extreme) return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	// one frame: pixels, then nflush trailing transactions
	task automatic send_frame(input int unsigned w, h, input int nflush, input bit extreme);
		for (int i = 0; i < w * h; i++) begin
			send_pixel(rand_level(extreme), rand_level(extreme), rand_level(extreme),
				$urandom_range(15) == 0);
			rand_sent++;
		end
		for (int i = 0; i < nflush; i++) begin
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
			rand_sent++;
		end
	endtask

	function automatic int unsigned clamp_w(input int unsigned v);
		return (v == 0) ? 1 : (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v;
	endfunction

	function automatic int unsigned clamp_h(input int unsigned v);
		return (v == 0) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
	endfunction

	initial begin
		int unsigned w, h;
		int nf, sel;
		arst_n = 1'b0;
		valid = 1'b0;
		flush = 1'b0;
		pixel_red = '0;
		pixel_green = '0;
		pixel_blue = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		rand_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 3x3 frame of full-scale steps: red checkerboard, green top row, blue left column
		write_reg(ADDR_WIDTH, 32'd3);
		write_reg(ADDR_HEIGHT, 32'd3);
		for (int i = 0; i < 9; i++) begin
			send_pixel((i % 2) ? 8'hFF : 8'h00, (i < 3) ? 8'hFF : 8'h00,
				(i % 3 == 0) ? 8'hFF : 8'h00, i == 4);
			rand_sent++;
		end
		for (int i = 0; i < 4; i++) begin
			send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
			rand_sent++;
		end
		// zero sizes act as a single pixel
		write_reg(ADDR_WIDTH, 32'd0);
		write_reg(ADDR_HEIGHT, 32'd0);
		send_frame(1, 1, 2, 1'b1);
		// a wider frame over two rows; no idling here
		calm = 1'b1;
		write_reg(ADDR_WIDTH, 32'd200);
		write_reg(ADDR_HEIGHT, 32'd2);
		send_frame(200, 2, 201, 1'b0);
		calm = 1'b0;

		// random small frames, sometimes with short or missing flush
		cur_w = 200;
		cur_h = 2;
		while (rand_sent < 1800) begin
			sel = $urandom_range(9);
			if (sel < 5) begin
				w = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				h = $urandom_range(6, 1);
				write_reg(ADDR_WIDTH, w);
				write_reg(ADDR_HEIGHT, h);
				cur_w = clamp_w(w);
				cur_h = clamp_h(h);
			end else if (sel == 5) begin
				h = $urandom_range(6, 0);
				write_reg(ADDR_HEIGHT, h);
				cur_h = clamp_h(h);
			end else if (sel == 6) begin
				w = $urandom_range(8, 0);
				write_reg(ADDR_WIDTH, w);
				cur_w = clamp_w(w);
			end
			calm = ($urandom_range(7) == 0);
			nf = ($urandom_range(99) < 85) ? cur_w + 1 : $urandom_range(cur_w, 0);
			send_frame(cur_w, cur_h, nf, $urandom_range(7) == 0);
		end
		calm = 1'b0;

		valid <= 1'b0;
		@(posedge clk);
		while (edges_pending != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	// a missing edge or a hung handshake ends here
	initial begin
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_line_mem.sv
hdl/sem_filter.sv
hdl/sobel_edge_magnitude_rgb_unit.sv
tb/sem_checker.sv
tb/testbench.sv
